@@ hw/rtl/lrts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrts_pkg: shared types and constants for the run-and-tumble lattice core
// Transfer payloads, controller/datapath command and status groups, codes.
// ============================================================================
package lrts_pkg;

    localparam int DEF_GRID_W        = 64;
    localparam int DEF_GRID_H        = 64;
    localparam int DEF_SITE_CAP      = 3;
    localparam int DEF_MAX_PARTICLES = 4096;

    localparam int PART_W   = 12;
    localparam int COORD_W  = 6;
    localparam int DRAW_W   = 16;
    localparam int HEAD_W   = 2;
    localparam int STAT_W   = 2;
    localparam int PCOUNT_W = 13;

    localparam int COORD_RANGE = 1 << COORD_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [HEAD_W-1:0] head_t;
    localparam head_t HD_PX = 2'd0;
    localparam head_t HD_PY = 2'd1;
    localparam head_t HD_NX = 2'd2;
    localparam head_t HD_NY = 2'd3;

    typedef logic [STAT_W-1:0] stat_t;
    localparam stat_t ST_OK    = 2'd0;
    localparam stat_t ST_FULL  = 2'd1;
    localparam stat_t ST_RANGE = 2'd2;

    localparam logic MODE_PLACE = 1'b0;
    localparam logic MODE_MOVE  = 1'b1;

    localparam logic REG_TUMBLE = 1'b0;
    localparam logic REG_PCOUNT = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [PART_W-1:0]   particle;
        logic [COORD_W-1:0]  site_x;
        logic [COORD_W-1:0]  site_y;
        logic [DRAW_W-1:0]   random_draw;
        head_t               new_heading;
    } in_item_t;

    typedef struct packed {
        logic [PART_W-1:0]   which_particle;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        head_t               heading;
        logic                moved;
        stat_t               status;
    } out_item_t;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic look_rd;
        logic early_commit;
        logic upd_commit;
        logic wb_commit;
        logic res_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic early_done;
    } dp_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/lrts_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrts_regs: configuration register file
// APB-style slave holding the tumble threshold and the particle count.
// ============================================================================
module lrts_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrts_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lrts_pkg::APB_DW-1:0]   pwdata,
    output logic      [lrts_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output logic      [lrts_pkg::DRAW_W-1:0]   tumble_threshold,
    output logic      [lrts_pkg::PCOUNT_W-1:0] particle_count
);
    import lrts_pkg::*;

    logic [DRAW_W-1:0]   thr_reg, thr_next;
    logic [PCOUNT_W-1:0] pcnt_reg, pcnt_next;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];

    always_comb begin
        thr_next  = thr_reg;
        pcnt_next = pcnt_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_TUMBLE: thr_next  = pwdata[DRAW_W-1:0];
                REG_PCOUNT: pcnt_next = pwdata[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TUMBLE: prdata = APB_DW'(thr_reg);
            REG_PCOUNT: prdata = APB_DW'(pcnt_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            pcnt_reg <= '0;
        end else begin
            thr_reg  <= thr_next;
            pcnt_reg <= pcnt_next;
        end
    end

    assign tumble_threshold = thr_reg;
    assign particle_count   = pcnt_reg;

endmodule
`default_nettype wire

@@ hw/rtl/lrts_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrts_dpath: lattice datapath
// Site occupancy memory, particle record memory, move and tumble logic.
// ============================================================================
module lrts_dpath #(
    parameter int GRID_W        = lrts_pkg::DEF_GRID_W,
    parameter int GRID_H        = lrts_pkg::DEF_GRID_H,
    parameter int SITE_CAP      = lrts_pkg::DEF_SITE_CAP,
    parameter int MAX_PARTICLES = lrts_pkg::DEF_MAX_PARTICLES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lrts_pkg::dp_cmd_t             cmd,
    output lrts_pkg::dp_sts_t                  sts,
    input  wire lrts_pkg::in_item_t            s_data,
    output lrts_pkg::out_item_t                m_data,
    input  wire logic [lrts_pkg::DRAW_W-1:0]   tumble_threshold,
    input  wire logic [lrts_pkg::PCOUNT_W-1:0] particle_count
);
    import lrts_pkg::*;

    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);
    localparam int SAW    = XW + YW;
    localparam int SDEPTH = 1 << SAW;
    localparam int CW     = $clog2(SITE_CAP + 1);
    localparam int PAW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int RECW   = HEAD_W + SAW;

    logic [CW-1:0]   cnt_mem [SDEPTH];
    logic [RECW-1:0] prt_mem [MAX_PARTICLES];

    logic [XW-1:0] x_mod_tab [COORD_RANGE];
    logic [YW-1:0] y_mod_tab [COORD_RANGE];

    for (genvar i = 0; i < COORD_RANGE; i++) begin : g_mod_tab
        assign x_mod_tab[i] = XW'(i % GRID_W);
        assign y_mod_tab[i] = YW'(i % GRID_H);
    end

    in_item_t        item_reg;
    logic [RECW-1:0] prt_rd_reg;
    logic [CW-1:0]   cnt_a_rd_reg;
    logic [CW-1:0]   cnt_b_rd_reg;
    logic [SAW-1:0]  clr_addr_reg;
    out_item_t       res_reg;

    logic [XW-1:0]   px_in, px_item, rec_x, tx;
    logic [YW-1:0]   py_in, py_item, rec_y, ty;
    head_t           rec_h, new_h;
    logic            oor, is_place, place_full, place_we, moved, tumble;
    logic [SAW-1:0]  rd_a_addr;
    logic            cnt_we;
    logic [SAW-1:0]  cnt_waddr;
    logic [CW-1:0]   cnt_wdata;
    logic            prt_we;
    logic [RECW-1:0] prt_wdata;
    out_item_t       res_next;

    assign px_in   = x_mod_tab[s_data.site_x];
    assign py_in   = y_mod_tab[s_data.site_y];
    assign px_item = x_mod_tab[item_reg.site_x];
    assign py_item = y_mod_tab[item_reg.site_y];

    assign rec_x = prt_rd_reg[XW-1:0];
    assign rec_y = prt_rd_reg[SAW-1:XW];
    assign rec_h = prt_rd_reg[RECW-1:SAW];

    always_comb begin
        tx = rec_x;
        ty = rec_y;
        case (rec_h)
            HD_PX: tx = (rec_x == XW'(GRID_W - 1)) ? '0 : rec_x + XW'(1);
            HD_NX: tx = (rec_x == '0) ? XW'(GRID_W - 1) : rec_x - XW'(1);
            HD_PY: ty = (rec_y == YW'(GRID_H - 1)) ? '0 : rec_y + YW'(1);
            HD_NY: ty = (rec_y == '0) ? YW'(GRID_H - 1) : rec_y - YW'(1);
            default: ;
        endcase
    end

    assign oor = ({1'b0, item_reg.particle} >= particle_count)
              || (32'(item_reg.particle) >= 32'(MAX_PARTICLES));
    assign is_place   = (item_reg.mode == MODE_PLACE);
    assign place_full = (cnt_a_rd_reg >= CW'(SITE_CAP));
    assign place_we   = cmd.early_commit && !oor && is_place && !place_full;
    assign moved      = (cnt_b_rd_reg < CW'(SITE_CAP));
    assign tumble     = (item_reg.random_draw < tumble_threshold);
    assign new_h      = tumble ? item_reg.new_heading : rec_h;

    assign sts.clr_last   = &clr_addr_reg;
    assign sts.early_done = oor || is_place;

    assign rd_a_addr = cmd.accept ? {py_in, px_in} : {rec_y, rec_x};

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = clr_addr_reg;
        cnt_wdata = '0;
        if (cmd.clr_en) begin
            cnt_we = 1'b1;
        end else if (place_we) begin
            cnt_we    = 1'b1;
            cnt_waddr = {py_item, px_item};
            cnt_wdata = cnt_a_rd_reg + CW'(1);
        end else if (cmd.upd_commit && moved) begin
            cnt_we    = 1'b1;
            cnt_waddr = {ty, tx};
            cnt_wdata = cnt_b_rd_reg + CW'(1);
        end else if (cmd.wb_commit && moved && (cnt_a_rd_reg != '0)) begin
            cnt_we    = 1'b1;
            cnt_waddr = {rec_y, rec_x};
            cnt_wdata = cnt_a_rd_reg - CW'(1);
        end
    end

    assign prt_we    = place_we || cmd.upd_commit;
    assign prt_wdata = place_we ? {item_reg.new_heading, py_item, px_item}
                                : {new_h, (moved ? {ty, tx} : {rec_y, rec_x})};

    always_comb begin
        res_next.which_particle = item_reg.particle;
        res_next.pos_x          = '0;
        res_next.pos_y          = '0;
        res_next.heading        = HD_PX;
        res_next.moved          = 1'b0;
        res_next.status         = ST_OK;
        if (oor) begin
            res_next.status = ST_RANGE;
        end else if (is_place) begin
            if (place_full) begin
                res_next.status = ST_FULL;
            end else begin
                res_next.pos_x   = COORD_W'(px_item);
                res_next.pos_y   = COORD_W'(py_item);
                res_next.heading = item_reg.new_heading;
            end
        end else begin
            res_next.pos_x   = COORD_W'(moved ? tx : rec_x);
            res_next.pos_y   = COORD_W'(moved ? ty : rec_y);
            res_next.heading = new_h;
            res_next.moved   = moved;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.accept || cmd.look_rd) begin
            cnt_a_rd_reg <= cnt_mem[rd_a_addr];
        end
        if (cmd.look_rd) begin
            cnt_b_rd_reg <= cnt_mem[{ty, tx}];
        end
    end

    always_ff @(posedge aclk) begin
        if (prt_we) begin
            prt_mem[PAW'(item_reg.particle)] <= prt_wdata;
        end
        if (cmd.accept) begin
            prt_rd_reg <= prt_mem[PAW'(s_data.particle)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.res_ld) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_addr_reg <= clr_addr_reg + SAW'(1);
        end
    end

    assign m_data = res_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (cnt_wdata <= CW'(SITE_CAP)))
        else $error("site count written above the cap");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_en, cmd.accept, cmd.look_rd, cmd.early_commit,
                  cmd.upd_commit, cmd.wb_commit}))
        else $error("more than one datapath command active");

    a_move_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd_commit |-> ({ty, tx} != {rec_y, rec_x}))
        else $error("move target equals its source site");

endmodule
`default_nettype wire

@@ hw/rtl/lrts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lrts_ctrl: sequencing controller
// Clearing pass, item acceptance, read-modify-write steps and result handoff.
// ============================================================================
module lrts_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lrts_pkg::dp_cmd_t      cmd,
    input  wire lrts_pkg::dp_sts_t sts
);
    import lrts_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (sts.early_done) begin
                    if (out_free) begin
                        cmd.early_commit = 1'b1;
                        cmd.res_ld       = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else begin
                    cmd.look_rd = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd_commit = 1'b1;
                state_next     = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    cmd.wb_commit = 1'b1;
                    cmd.res_ld    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_ld |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    a_upd_to_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |=> (state_reg == S_WB))
        else $error("update step not followed by write-back");

    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_LOOK))
        else $error("accepted item did not enter lookup");

endmodule
`default_nettype wire

@@ hw/rtl/lattice_run_tumble_step_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lattice_run_tumble_step_core: run-and-tumble lattice with site exclusion
//
// Items arrive on the s_ channel (valid/ready) and each produces one result
// on the m_ channel. A place item puts a particle on a site unless the site
// is full; a move item steps a particle along its director with wraparound
// when the target site is below the cap, then may replace the director.
// The APB port holds the tumble threshold and the particle count; write it
// only while no item is in flight.
// A place or rejected item has its result registered in the lookup step once
// the result register is free; s_ready stays low until the controller is idle.
// A move item steps through record read, two site count reads, target write,
// source write, its result registered with the source write; the single write
// port of the site count memory keeps the target and source writes apart.
// After reset a clearing pass zeroes the site count memory, one entry per
// cycle over all 2**(clog2(GRID_W)+clog2(GRID_H)) entries (4096 by default),
// with s_ready low; configuration writes are taken during the pass.
// When the receiver stalls, the result register holds; one further item is
// accepted and waits with its result until the register is free.
// ============================================================================
module lattice_run_tumble_step_core #(
    parameter int GRID_W        = lrts_pkg::DEF_GRID_W,
    parameter int GRID_H        = lrts_pkg::DEF_GRID_H,
    parameter int SITE_CAP      = lrts_pkg::DEF_SITE_CAP,
    parameter int MAX_PARTICLES = lrts_pkg::DEF_MAX_PARTICLES
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire lrts_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lrts_pkg::out_item_t              m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lrts_pkg::APB_AW-1:0] paddr,
    input  wire logic [lrts_pkg::APB_DW-1:0] pwdata,
    output logic      [lrts_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import lrts_pkg::*;

    dp_cmd_t             cmd;
    dp_sts_t             sts;
    logic [DRAW_W-1:0]   tumble_threshold;
    logic [PCOUNT_W-1:0] particle_count;

    lrts_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .tumble_threshold (tumble_threshold),
        .particle_count   (particle_count)
    );

    lrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lrts_dpath #(
        .GRID_W        (GRID_W),
        .GRID_H        (GRID_H),
        .SITE_CAP      (SITE_CAP),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_data           (s_data),
        .m_data           (m_data),
        .tumble_threshold (tumble_threshold),
        .particle_count   (particle_count)
    );

endmodule
`default_nettype wire
